// ===== rtl/utf8_no_bom_validator_assert.svh =====
// Assertion macros for the UTF-8 validator checks.
`ifndef UTF8_NO_BOM_VALIDATOR_ASSERT_SVH
`define UTF8_NO_BOM_VALIDATOR_ASSERT_SVH

// Clocked check, disabled while reset is low.
`define UNBV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with a fixed message.
`define UNBV_CHECK(lbl, clk, rst_n, prop) \
	`UNBV_ASSERT(lbl, clk, rst_n, prop, "utf8 validator check failed")

`endif

// ===== rtl/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 validator.
`default_nettype none
package utf8v_pkg;
	localparam int POSITION_BITS = 32;
	localparam int OFFSET_W      = 32;
	localparam int VERDICT_W     = 3;
	localparam int IN_TDATA_W    = 8;
	localparam int OUT_PAD_W     = 5;
	localparam int OUT_TDATA_W   = VERDICT_W + OFFSET_W + OUT_PAD_W;

	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] MASK_F0 = 8'hF0;
	localparam logic [7:0] MASK_F8 = 8'hF8;
	localparam logic [7:0] MASK_C0 = 8'hC0;
	localparam logic [7:0] LEAD2   = 8'hC0;
	localparam logic [7:0] LEAD3   = 8'hE0;
	localparam logic [7:0] LEAD4   = 8'hF0;
	localparam logic [7:0] CONT    = 8'h80;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_VALID     = 3'd0,
		VERDICT_BOM       = 3'd1,
		VERDICT_BAD_LEAD  = 3'd2,
		VERDICT_TRUNCATED = 3'd3,
		VERDICT_BAD_CONT  = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		verdict_t              verdict;
		logic [OFFSET_W-1:0]   error_offset;
	} result_t;

	// Byte order mark, EF BB BF.
	function automatic logic [7:0] mark_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0:    m = 8'hEF;
			2'd1:    m = 8'hBB;
			2'd2:    m = 8'hBF;
			default: m = 8'h00;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/utf8v_in_reg.sv =====
// Input register for incoming bytes and the advance decision.
`default_nettype none
module utf8v_in_reg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [utf8v_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                              s_tlast,
	input  wire logic                              out_free,
	output utf8v_pkg::item_t                       item,
	output logic                                   advance
);
	import utf8v_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// A non-final byte never waits for the result register.
	assign advance  = valid_s1 && (!item_s1.end_of_file || out_free);
	assign s_tready = !valid_s1 || advance;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte   <= s_tdata[7:0];
			item_s1.end_of_file <= s_tlast;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/utf8v_step.sv =====
// Per-byte UTF-8 decode state and verdict logic.
`default_nettype none
module utf8v_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  utf8v_pkg::item_t item,
	output utf8v_pkg::result_t result
);
	import utf8v_pkg::*;

	logic [POSITION_BITS-1:0] byte_offset_q, byte_offset_n;
	logic [1:0]               expect_q, expect_n;
	logic [POSITION_BITS-1:0] lead_offset_q, lead_offset_n;
	logic                     pend_q, pend_n;
	logic [POSITION_BITS-1:0] pend_offset_q, pend_offset_n;
	logic                     mark_q, mark_n;
	verdict_t                 err_q, err_n;
	logic [POSITION_BITS-1:0] err_pos_q, err_pos_n;

	logic [7:0]               b;
	logic [POSITION_BITS-1:0] pos;

	always_comb begin
		b             = item.data_byte;
		pos           = byte_offset_q;
		expect_n      = expect_q;
		lead_offset_n = lead_offset_q;
		pend_n        = pend_q;
		pend_offset_n = pend_offset_q;
		mark_n        = mark_q;
		err_n         = err_q;
		err_pos_n     = err_pos_q;

		if (err_q == VERDICT_VALID) begin
			if (expect_q == 2'd0) begin
				lead_offset_n = pos;
				pend_n        = 1'b0;
				if (!b[7]) begin
					expect_n = 2'd0;
				end else if ((b & MASK_E0) == LEAD2) begin
					expect_n = 2'd1;
				end else if ((b & MASK_F0) == LEAD3) begin
					expect_n = 2'd2;
				end else if ((b & MASK_F8) == LEAD4) begin
					expect_n = 2'd3;
				end else begin
					err_n     = VERDICT_BAD_LEAD;
					err_pos_n = pos;
				end
			end else begin
				if ((b & MASK_C0) != CONT && !pend_q) begin
					pend_n        = 1'b1;
					pend_offset_n = pos;
				end
				expect_n = expect_q - 2'd1;
				// bad continuation commits only once the sequence is complete
				if (expect_n == 2'd0 && pend_n) begin
					err_n     = VERDICT_BAD_CONT;
					err_pos_n = pend_offset_n;
					pend_n    = 1'b0;
				end
			end
		end

		if (mark_q && pos < POSITION_BITS'(3)) begin
			if (b != mark_byte(pos[1:0])) begin
				mark_n = 1'b0;
			end else if (pos == POSITION_BITS'(2)) begin
				err_n     = VERDICT_BOM;
				err_pos_n = '0;
			end
		end

		byte_offset_n = (&pos) ? pos : pos + POSITION_BITS'(1);

		if (item.end_of_file && err_n == VERDICT_VALID && expect_n != 2'd0) begin
			err_n     = VERDICT_TRUNCATED;
			err_pos_n = lead_offset_n;
		end

		result.verdict      = err_n;
		result.error_offset = (err_n == VERDICT_VALID) ? '0 : err_pos_n[OFFSET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			expect_q      <= 2'd0;
			lead_offset_q <= '0;
			pend_q        <= 1'b0;
			pend_offset_q <= '0;
			mark_q        <= 1'b1;
			err_q         <= VERDICT_VALID;
			err_pos_q     <= '0;
		end else if (advance) begin
			if (item.end_of_file) begin
				byte_offset_q <= '0;
				expect_q      <= 2'd0;
				lead_offset_q <= '0;
				pend_q        <= 1'b0;
				pend_offset_q <= '0;
				mark_q        <= 1'b1;
				err_q         <= VERDICT_VALID;
				err_pos_q     <= '0;
			end else begin
				byte_offset_q <= byte_offset_n;
				expect_q      <= expect_n;
				lead_offset_q <= lead_offset_n;
				pend_q        <= pend_n;
				pend_offset_q <= pend_offset_n;
				mark_q        <= mark_n;
				err_q         <= err_n;
				err_pos_q     <= err_pos_n;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/utf8v_out_reg.sv =====
// Result register holding the verdict until it is taken.
`default_nettype none
module utf8v_out_reg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  utf8v_pkg::result_t                      result,
	output logic                                    out_free,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [utf8v_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import utf8v_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {OUT_PAD_W'(0), result_q.error_offset, result_q.verdict};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/utf8_no_bom_validator.sv =====
// Top level of the UTF-8 file validator without byte order mark.
// Takes one byte of a file per cycle on the s_ stream, tlast marking the
// file's final byte, and gives one verdict item on the m_ stream per file:
// valid, or the first error (leading EF BB BF mark, bad lead byte, sequence
// truncated at end of file, bad continuation) with its byte position.
// Each byte passes an input register, then combinational decode logic into
// the decode state; for the final byte the verdict is then loaded into
// the result register. Bytes are taken back to back at one per
// cycle; input stalls only when a final byte waits on a full result
// register that is not being read. State returns to reset after each file.
`default_nettype none
module utf8_no_bom_validator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [utf8v_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
	input  wire logic                              s_tlast,  // end_of_file
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [utf8v_pkg::OUT_TDATA_W-1:0]      m_tdata   // [2:0] verdict,
	                                                         // [34:3] error_offset,
	                                                         // [39:35] zero
);
	import utf8v_pkg::*;

	item_t   item;
	result_t result;
	logic    advance;
	logic    out_free;

	utf8v_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.item     (item),
		.advance  (advance)
	);

	utf8v_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item),
		.result  (result)
	);

	utf8v_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && item.end_of_file),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule
`default_nettype wire

// ===== rtl/utf8v_checker.sv =====
// Port-level checks on the UTF-8 validator, bound to the top level.
`default_nettype none
`include "utf8_no_bom_validator_assert.svh"
module utf8v_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [utf8v_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import utf8v_pkg::*;

	`UNBV_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "verdict dropped or changed while stalled")
	`UNBV_CHECK(a_valid_zero_offset, clk, arst_n, m_tvalid && m_tdata[2:0] == VERDICT_VALID |-> m_tdata[34:3] == '0)
	`UNBV_CHECK(a_bom_zero_offset, clk, arst_n, m_tvalid && m_tdata[2:0] == VERDICT_BOM |-> m_tdata[34:3] == '0)
	`UNBV_CHECK(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[OUT_TDATA_W-1:VERDICT_W+OFFSET_W] == '0)
	`UNBV_CHECK(a_ready_through, clk, arst_n, m_tready |-> s_tready)
endmodule

bind utf8_no_bom_validator utf8v_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/tb_utf8_no_bom_validator.sv =====
// Self-checking testbench for utf8_no_bom_validator: predicts each file verdict and checks it.
`timescale 1ns / 100ps
module tb_utf8_no_bom_validator;
	import utf8v_pkg::*;

	localparam logic [23:0] BOM_SEQ = 24'hEFBBBF;

	class utf8_scoreboard;
		logic [OFFSET_W-1:0] next_pos;
		logic [1:0]          owed;
		logic [OFFSET_W-1:0] lead_pos;
		bit                  cont_bad;
		logic [OFFSET_W-1:0] cont_bad_pos;
		bit                  mark_ok;
		verdict_t            err;
		logic [OFFSET_W-1:0] err_pos;
		result_t             verdicts[$];
		int                  fails;
		int                  checked;
		int                  byte_count;
		int                  file_count;
		int                  tally[5];

		function new();
			fails = 0;
			checked = 0;
			byte_count = 0;
			file_count = 0;
			foreach (tally[i])
				tally[i] = 0;
			clear();
		endfunction

		function void clear();
			next_pos = '0;
			owed = 2'd0;
			lead_pos = '0;
			cont_bad = 1'b0;
			cont_bad_pos = '0;
			mark_ok = 1'b1;
			err = VERDICT_VALID;
			err_pos = '0;
		endfunction

		function void commit(verdict_t code, logic [OFFSET_W-1:0] pos);
			if (err == VERDICT_VALID) begin
				err = code;
				err_pos = pos;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		// Accepted input byte: advance the file state, queue a verdict on end of file.
		function void note_byte(logic [7:0] b, logic eof);
			logic [OFFSET_W-1:0] pos;
			result_t r;
			pos = next_pos;
			byte_count++;
			if (err == VERDICT_VALID) begin
				if (owed == 2'd0) begin
					lead_pos = pos;
					cont_bad = 1'b0;
					if (b[7] == 1'b0)
						owed = 2'd0;
					else if ((b & 8'hE0) == 8'hC0)
						owed = 2'd1;
					else if ((b & 8'hF0) == 8'hE0)
						owed = 2'd2;
					else if ((b & 8'hF8) == 8'hF0)
						owed = 2'd3;
					else
						commit(VERDICT_BAD_LEAD, pos);
				end else begin
					if (b[7:6] != 2'b10 && !cont_bad) begin
						cont_bad = 1'b1;
						cont_bad_pos = pos;
					end
					owed = owed - 2'd1;
					if (owed == 2'd0 && cont_bad) begin
						commit(VERDICT_BAD_CONT, cont_bad_pos);
						cont_bad = 1'b0;
					end
				end
			end
			if (mark_ok && pos < 3) begin
				if (b != BOM_SEQ[8*(2-pos[1:0]) +: 8])
					mark_ok = 1'b0;
				else if (pos == 2) begin
					err = VERDICT_BOM;
					err_pos = '0;
				end
			end
			if (next_pos != '1)
				next_pos = next_pos + 1'b1;
			if (eof) begin
				if (err == VERDICT_VALID && owed != 2'd0)
					commit(VERDICT_TRUNCATED, lead_pos);
				r.verdict = err;
				r.error_offset = (err == VERDICT_VALID) ? '0 : err_pos;
				verdicts.push_back(r);
				tally[int'(err)]++;
				file_count++;
				clear();
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] word);
			result_t want;
			logic [VERDICT_W-1:0] got_v;
			logic [OFFSET_W-1:0] got_off;
			got_v = word[VERDICT_W-1:0];
			got_off = word[VERDICT_W +: OFFSET_W];
			if (verdicts.size() == 0) begin
				report($sformatf("verdict %0d offset %0d with no file pending", got_v, got_off));
				return;
			end
			want = verdicts.pop_front();
			checked++;
			if (got_v != want.verdict)
				report($sformatf("verdict got %0d want %0d", got_v, want.verdict));
			if (got_off != want.error_offset)
				report($sformatf("error offset got %0d want %0d", got_off, want.error_offset));
			if (word[OUT_TDATA_W-1:VERDICT_W+OFFSET_W] != '0)
				report($sformatf("pad bits not zero: %h", word[OUT_TDATA_W-1:VERDICT_W+OFFSET_W]));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	utf8_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int sent = 0;

	utf8_no_bom_validator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= hold_len;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	task automatic send_item(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eof;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// Sends the low n bytes of w as one file, most significant first.
	task automatic send_packed(input logic [31:0] w, input int n);
		for (int i = 0; i < n; i++)
			send_item(w[8*(n-1-i) +: 8], i == n - 1);
	endtask

	function automatic logic [7:0] cont_byte();
		logic [7:0] c;
		c = 8'($urandom_range(63));
		c[7] = 1'b1;
		return c;
	endfunction

	task automatic random_file();
		logic [7:0] q[$];
		logic [7:0] lead;
		int shape;
		int nchars;
		shape = $urandom_range(99);
		if (shape < 8) begin
			repeat ($urandom_range(1, 10))
				q.push_back(8'($urandom_range(255)));
		end else begin
			if ($urandom_range(15) == 0) begin
				q.push_back(8'hEF);
				q.push_back(8'hBB);
				q.push_back(8'hBF);
			end
			nchars = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			repeat (nchars) begin
				case ($urandom_range(3))
					0: q.push_back(8'($urandom_range(127)));
					1: begin
						lead = 8'($urandom_range(31));
						q.push_back(8'hC0 | lead);
						q.push_back(cont_byte());
					end
					2: begin
						lead = 8'($urandom_range(15));
						q.push_back(8'hE0 | lead);
						repeat (2) q.push_back(cont_byte());
					end
					default: begin
						lead = 8'($urandom_range(7));
						q.push_back(8'hF0 | lead);
						repeat (3) q.push_back(cont_byte());
					end
				endcase
			end
			if (shape < 22) begin
				q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
			end else if (shape < 34) begin
				repeat ($urandom_range(1, 3))
					if (q.size() > 1)
						void'(q.pop_back());
			end
		end
		for (int i = 0; i < q.size(); i++)
			send_item(q[i], i == q.size() - 1);
	endtask

	initial begin
		int target;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files
		send_packed(32'h00, 1);
		send_packed(32'h7F, 1);
		send_packed(32'hEFBBBF41, 4);
		send_packed(32'h80, 1);
		send_packed(32'hFF, 1);
		send_packed(32'hF8, 1);
		send_packed(32'h41C3, 2);
		send_packed(32'hC3A9, 2);
		send_packed(32'hF09080, 3);
		send_packed(32'hE228A1, 3);
		send_packed(32'hF09F9880, 4);
		send_packed(32'h80C3, 2);

		target = sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			target = target + 200;
			while (sent < target)
				random_file();
			if (phase == 0) begin
				// long hold-off on the output while short files keep coming
				hold_len = 400;
				hold_go = ~hold_go;
				repeat (40)
					if ($urandom_range(3) == 0)
						send_packed({16'h0000, 8'($urandom_range(63)) | 8'hC0, cont_byte()}, 2);
					else
						send_packed($urandom_range(255), 1);
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
		$display("covered %0d bytes in %0d files, %0d verdicts checked, with a long output hold-off",
			sb.byte_count, sb.file_count, sb.checked);
		$display("verdicts: valid %0d, mark %0d, bad lead %0d, truncated %0d, bad continuation %0d",
			sb.tally[0], sb.tally[1], sb.tally[2], sb.tally[3], sb.tally[4]);
		if (sb.fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout, %0d bytes sent", sent);
		$display("TB_ERROR");
		$finish;
	end
endmodule
